/* design/sfmm_pkg.sv */
// ----------------------------------------------------------------------------
// sfmm_pkg
// Shared types and constants for the suffix min/max Fenwick tree.
// ----------------------------------------------------------------------------
`default_nettype none

package sfmm_pkg;

	localparam int TREE_SIZE_DEF = 1024;
	localparam int POS_W         = 10;
	localparam int VAL_W         = 31;
	localparam int REQ_W         = 3;
	localparam int S_DATA_W      = 48;  // position + value, padded to bytes
	localparam int M_DATA_W      = 32;  // extreme_value, padded to bytes

	localparam logic signed [VAL_W-1:0] VAL_LIMIT = 31'sd1000000000;
	localparam logic signed [VAL_W-1:0] VAL_FLOOR = -31'sd1000000000;

	typedef enum logic [REQ_W-1:0] {
		REQ_UPD_MIN = 3'd0,
		REQ_UPD_MAX = 3'd1,
		REQ_QRY_MIN = 3'd2,
		REQ_QRY_MAX = 3'd3,
		REQ_CLEAR   = 3'd4
	} req_t;

	// memory port controls issued by the walker
	typedef struct packed {
		logic re;
		logic we_min;
		logic we_max;
	} mem_ctl_t;

endpackage

`default_nettype wire

/* design/suffix_min_max_fenwick_tree.sv */
// Walk: an accepted update or query walks the tree entry by entry; a query's
// result word is registered once the walk is done and the output is free.
// Only one item is in flight: no new word is accepted until the walk (and, for a
// query, the registering of the result word) is done.
// Reset and clear requests start a clearing pass over all TREE_SIZE entries (1024 by
// default) that rewrites both tables; no words are accepted meanwhile.
// ----------------------------------------------------------------------------
// suffix_min_max_fenwick_tree
// Binary indexed tree keeping suffix minima and maxima in two RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module suffix_min_max_fenwick_tree #(
	parameter int TREE_SIZE = sfmm_pkg::TREE_SIZE_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [sfmm_pkg::S_DATA_W-1:0]   s_tdata,  // position[9:0], value[40:10]
	input  wire logic [sfmm_pkg::REQ_W-1:0]      s_tuser,  // req_type[2:0]
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic [sfmm_pkg::M_DATA_W-1:0]        m_tdata   // extreme_value[30:0]
);

	import sfmm_pkg::*;

	localparam int AW = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1;

	mem_ctl_t                mem_ctl;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic signed [VAL_W-1:0] min_wdata;
	logic signed [VAL_W-1:0] max_wdata;
	logic signed [VAL_W-1:0] min_rdata;
	logic signed [VAL_W-1:0] max_rdata;
	logic signed [VAL_W-1:0] extreme_value;

	assign m_tdata = {{(M_DATA_W-VAL_W){1'b0}}, extreme_value};

	sfmm_walk #(
		.TREE_SIZE (TREE_SIZE)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.position      (s_tdata[POS_W-1:0]),
		.value         (s_tdata[POS_W+VAL_W-1:POS_W]),
		.req_type      (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.extreme_value (extreme_value),
		.mem_ctl       (mem_ctl),
		.waddr         (waddr),
		.min_wdata     (min_wdata),
		.max_wdata     (max_wdata),
		.raddr         (raddr),
		.min_rdata     (min_rdata),
		.max_rdata     (max_rdata)
	);

	sfmm_ram #(
		.DEPTH (TREE_SIZE),
		.DW    (VAL_W)
	) u_min_ram (
		.clk   (clk),
		.we    (mem_ctl.we_min),
		.waddr (waddr),
		.wdata (min_wdata),
		.re    (mem_ctl.re),
		.raddr (raddr),
		.rdata (min_rdata)
	);

	sfmm_ram #(
		.DEPTH (TREE_SIZE),
		.DW    (VAL_W)
	) u_max_ram (
		.clk   (clk),
		.we    (mem_ctl.we_max),
		.waddr (waddr),
		.wdata (max_wdata),
		.re    (mem_ctl.re),
		.raddr (raddr),
		.rdata (max_rdata)
	);

endmodule

`default_nettype wire

/* design/sfmm_ram.sv */
// ----------------------------------------------------------------------------
// sfmm_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmm_ram #(
	parameter  int DEPTH = 1024,
	parameter  int DW    = 31,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/sfmm_walk.sv */
// ----------------------------------------------------------------------------
// sfmm_walk
// Request decode and tree walk: read-modify-write for updates, running
// min/max for queries, and the table clearing sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module sfmm_walk #(
	parameter  int TREE_SIZE = sfmm_pkg::TREE_SIZE_DEF,
	localparam int AW        = (TREE_SIZE > 1) ? $clog2(TREE_SIZE) : 1
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// request word
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [sfmm_pkg::POS_W-1:0]          position,
	input  wire logic signed [sfmm_pkg::VAL_W-1:0]   value,
	input  wire logic [sfmm_pkg::REQ_W-1:0]          req_type,
	// result word
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic signed [sfmm_pkg::VAL_W-1:0]        extreme_value,
	// table memories
	output sfmm_pkg::mem_ctl_t                       mem_ctl,
	output logic [AW-1:0]                            waddr,
	output logic signed [sfmm_pkg::VAL_W-1:0]        min_wdata,
	output logic signed [sfmm_pkg::VAL_W-1:0]        max_wdata,
	output logic [AW-1:0]                            raddr,
	input  wire logic signed [sfmm_pkg::VAL_W-1:0]   min_rdata,
	input  wire logic signed [sfmm_pkg::VAL_W-1:0]   max_rdata
);

	import sfmm_pkg::*;

	// walk index must hold any position and the step past the last entry
	localparam int WW = ((AW > POS_W) ? AW : POS_W) + 1;
	localparam logic [WW-1:0] SIZE_W = WW'(TREE_SIZE);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TREE_SIZE - 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_RESULT
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_cnt_q;
	logic                    rd_vld_s1;
	logic                    is_max_q;
	logic                    is_query_q;
	logic [WW-1:0]           idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] acc_q;
	logic [AW-1:0]           rd_addr_s1;

	logic                    accept;
	logic signed [VAL_W-1:0] val_sat;
	logic                    in_range;
	logic                    live;
	logic                    issue_rd;
	logic [WW-1:0]           low_bit;
	logic [WW-1:0]           idx_next;
	logic signed [VAL_W-1:0] rd_data;
	logic                    better;
	logic signed [VAL_W-1:0] acc_next;
	logic                    walk_done;
	logic                    out_free;

	function automatic logic signed [VAL_W-1:0] saturate(input logic signed [VAL_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		r = v;
		if (v > VAL_LIMIT) begin
			r = VAL_LIMIT;
		end else if (v < VAL_FLOOR) begin
			r = VAL_FLOOR;
		end
		return r;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign val_sat  = saturate(value);
	assign out_free = !m_tvalid || m_tready;

	// queries stop at the top of the table, updates run down to zero
	assign in_range = (idx_q < SIZE_W);
	assign live     = is_query_q ? ((idx_q != '0) && in_range) : (idx_q != '0);
	assign issue_rd = (state_q == ST_WALK) && live && in_range;
	assign low_bit  = idx_q & (~idx_q + WW'(1));
	assign idx_next = is_query_q ? (idx_q + low_bit) : (idx_q & (idx_q - WW'(1)));

	assign rd_data  = is_max_q ? max_rdata : min_rdata;
	assign better   = is_max_q ? (val_q > rd_data) : (val_q < rd_data);
	always_comb begin
		acc_next = acc_q;
		if (is_max_q) begin
			if (rd_data > acc_q) begin
				acc_next = rd_data;
			end
		end else begin
			if (rd_data < acc_q) begin
				acc_next = rd_data;
			end
		end
	end

	assign walk_done = (state_q == ST_WALK) && !live && !rd_vld_s1;

	// write of step n and read of step n+1 never hit the same entry
	always_comb begin
		mem_ctl.re     = issue_rd;
		mem_ctl.we_min = (state_q == ST_CLEAR) ||
			((state_q == ST_WALK) && rd_vld_s1 && !is_query_q && !is_max_q && better);
		mem_ctl.we_max = (state_q == ST_CLEAR) ||
			((state_q == ST_WALK) && rd_vld_s1 && !is_query_q && is_max_q && better);
		waddr     = (state_q == ST_CLEAR) ? clr_cnt_q : rd_addr_s1;
		min_wdata = (state_q == ST_CLEAR) ? VAL_LIMIT : val_q;
		max_wdata = (state_q == ST_CLEAR) ? VAL_FLOOR : val_q;
		raddr     = idx_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			rd_vld_s1     <= 1'b0;
			m_tvalid      <= 1'b0;
			extreme_value <= '0;
		end else begin
			rd_vld_s1 <= issue_rd;
			if ((state_q == ST_RESULT) && out_free) begin
				m_tvalid      <= 1'b1;
				extreme_value <= acc_q;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type inside {REQ_UPD_MIN, REQ_UPD_MAX, REQ_QRY_MIN,
						                     REQ_QRY_MAX}) begin
							state_q <= ST_WALK;
						end else if (req_type == REQ_CLEAR) begin
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end
					end
				end
				ST_WALK: begin
					if (walk_done) begin
						state_q <= is_query_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= idx_q[AW-1:0];
		if (accept) begin
			is_max_q   <= (req_type == REQ_UPD_MAX) || (req_type == REQ_QRY_MAX);
			is_query_q <= (req_type == REQ_QRY_MIN) || (req_type == REQ_QRY_MAX);
			idx_q      <= {{(WW-POS_W){1'b0}}, position};
			val_q      <= val_sat;
			acc_q      <= (req_type == REQ_QRY_MAX) ? VAL_FLOOR : VAL_LIMIT;
		end else if (state_q == ST_WALK) begin
			if (live) begin
				idx_q <= idx_next;
			end
			if (rd_vld_s1 && is_query_q) begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

`default_nettype wire
